// File: src/ght_pkg.sv
`default_nettype none
package ght_pkg;

    localparam int NUM_SLOTS_DEF = 1024;
    localparam int GEN_SHIFT_DEF = 12;

    localparam int ID_W    = 31;
    localparam int RUNS_W  = 32;
    localparam int SLOT_W  = 10;
    localparam int STATE_W = 3;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_LOOKUP  = 2'd1,
        ACT_DESTROY = 2'd2,
        ACT_RUN     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        RC_OK     = 2'd0,
        RC_NOFREE = 2'd1,
        RC_BAD    = 2'd2
    } t_rcode;

    typedef enum logic [STATE_W-1:0] {
        ES_FREE        = 3'd0,
        ES_DYING       = 3'd1,
        ES_RUNNABLE    = 3'd2,
        ES_RUNNING     = 3'd3,
        ES_NOT_RUNNABLE = 3'd4
    } t_estate;

endpackage
`default_nettype wire

// File: src/ght_ram.sv
`default_nettype none
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: src/generational_handle_table.sv
`default_nettype none
// Channel   Direction  Handshake                  Payload
// command   in         start high, busy low       i_action, i_target_id, i_parent_ident,
//                                                 i_check_permission
// result    out        o_result_valid, 1 cycle    o_result_code, o_result_id, o_slot_index,
//                                                 o_entry_state, o_entry_parent, o_entry_runs
//
// Sequence: allocate, lookup and destroy read the memory, then form the result and
// write back any change; a run that switches away from another current entry adds
// a fix-up state, since the old entry's state goes back through the single write port
// of the state memory. A new command beat is taken in the cycle its result shows,
// except after a switching run, where it waits until the fix-up state is done.
// Reset: synchronous, active low. No clearing pass: a fill count marks slots never
// handed out, which read as free with a zero identifier, so the block is ready at once.
// Stalls: none on the result side; each result is shown for exactly one cycle.
module generational_handle_table #(
    parameter int NUM_SLOTS = ght_pkg::NUM_SLOTS_DEF,
    parameter int GEN_SHIFT = ght_pkg::GEN_SHIFT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_action,
    input  wire logic [ght_pkg::ID_W-1:0]      i_target_id,
    input  wire logic [ght_pkg::ID_W-1:0]      i_parent_ident,
    input  wire logic                          i_check_permission,
    output logic                               o_result_valid,
    output logic [1:0]                         o_result_code,
    output logic [ght_pkg::ID_W-1:0]           o_result_id,
    output logic [ght_pkg::SLOT_W-1:0]         o_slot_index,
    output logic [ght_pkg::STATE_W-1:0]        o_entry_state,
    output logic [ght_pkg::ID_W-1:0]           o_entry_parent,
    output logic [ght_pkg::RUNS_W-1:0]         o_entry_runs
);

    import ght_pkg::*;

    // Slot index width, and free-list link width (must hold NUM_SLOTS as "empty")
    localparam int IW = $clog2(NUM_SLOTS);
    localparam int HW = $clog2(NUM_SLOTS + 1);

    // Main word: id | parent | runs | free link
    localparam int PAR_LO  = ID_W;
    localparam int RUNS_LO = 2 * ID_W;
    localparam int NEXT_LO = 2 * ID_W + RUNS_W;
    localparam int MW      = NEXT_LO + HW;

    localparam logic [31:0] GEN_STEP = 32'd1 << GEN_SHIFT;
    localparam logic [31:0] IDX_MASK = GEN_STEP - 32'd1;
    localparam logic [HW-1:0] HEAD_EMPTY = HW'(NUM_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIX
    } t_state;

    // Control
    t_state          r_state, n_state;
    logic [HW-1:0]   r_free_head, n_free_head;
    logic [HW-1:0]   r_fill, n_fill;
    logic [IW-1:0]   r_cur_slot, n_cur_slot;
    logic            r_cur_valid, n_cur_valid;
    logic [ID_W-1:0] r_cur_id, n_cur_id;
    logic            r_out_valid, n_out_valid;

    // Held command beat
    t_action         r_action, n_action;
    logic [ID_W-1:0] r_target, n_target;
    logic [ID_W-1:0] r_parent, n_parent;
    logic            r_perm, n_perm;
    logic [IW-1:0]   r_addr, n_addr;
    logic            r_fresh, n_fresh;
    logic            r_cur_ref, n_cur_ref;
    logic            r_bad_idx, n_bad_idx;
    logic [IW-1:0]   r_prev_slot, n_prev_slot;

    // Result payload
    t_rcode            r_code, n_code;
    logic [ID_W-1:0]   r_res_id, n_res_id;
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;
    t_estate           r_res_state, n_res_state;
    logic [ID_W-1:0]   r_res_parent, n_res_parent;
    logic [RUNS_W-1:0] r_res_runs, n_res_runs;

    // Memory ports
    logic              w_main_we, w_st_we;
    logic [IW-1:0]     w_raddr, w_waddr;
    logic [MW-1:0]     w_main_rdata, w_main_wdata;
    logic [STATE_W-1:0] w_st_rdata, w_st_wdata;

    // Accept-side decode
    logic              w_accept;
    logic [31:0]       w_idx32;

    // Execute-side decode
    logic [ID_W-1:0]   w_rd_id, w_rd_parent;
    logic [RUNS_W-1:0] w_rd_runs;
    logic [HW-1:0]     w_rd_next;
    t_estate           w_rd_state;
    logic [ID_W-1:0]   w_perm_id;
    logic              w_is_cur, w_resolved;
    logic [31:0]       w_gen_sum, w_gen, w_new_id32, w_slot32;
    logic [ID_W-1:0]   w_new_id;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Index bits of the target; out-of-table indices are flagged and never resolve
    assign w_idx32 = {1'b0, i_target_id} & IDX_MASK;

    always_comb begin
        if (t_action'(i_action) == ACT_ALLOC) begin
            w_raddr = r_free_head[IW-1:0];
        end else if (i_target_id == '0) begin
            w_raddr = r_cur_slot;
        end else begin
            w_raddr = w_idx32[IW-1:0];
        end
    end

    ght_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_SLOTS)
    ) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (w_main_we),
        .i_waddr (w_waddr),
        .i_wdata (w_main_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_main_rdata)
    );

    ght_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_SLOTS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_waddr),
        .i_wdata (w_st_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_st_rdata)
    );

    // Slots at or beyond the fill count were never handed out: free, id zero,
    // linked to the next slot
    always_comb begin
        w_rd_parent = w_main_rdata[PAR_LO +: ID_W];
        w_rd_runs   = w_main_rdata[RUNS_LO +: RUNS_W];
        if (r_fresh) begin
            w_rd_id    = '0;
            w_rd_state = ES_FREE;
            w_rd_next  = HW'(r_addr) + HW'(1);
        end else begin
            w_rd_id    = w_main_rdata[ID_W-1:0];
            w_rd_state = t_estate'(w_st_rdata);
            w_rd_next  = w_main_rdata[NEXT_LO +: HW];
        end
    end

    assign w_is_cur  = r_cur_valid && (r_cur_slot == r_addr);
    assign w_perm_id = r_cur_valid ? r_cur_id : '0;

    always_comb begin
        if (r_cur_ref) begin
            w_resolved = r_cur_valid;
        end else begin
            w_resolved = !r_bad_idx && (w_rd_state != ES_FREE) && (w_rd_id == r_target)
                      && (!r_perm || w_is_cur || (w_rd_parent == w_perm_id));
        end
    end

    // Next generation: bump, drop index bits, fall back to one generation on
    // zero or a set sign bit, then merge in the slot
    assign w_slot32   = 32'(r_addr);
    assign w_gen_sum  = {1'b0, w_rd_id} + GEN_STEP;
    assign w_gen      = w_gen_sum & ~IDX_MASK;
    assign w_new_id32 = (((w_gen == '0) || w_gen[31]) ? GEN_STEP : w_gen) | w_slot32;
    assign w_new_id   = w_new_id32[ID_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_fill       = r_fill;
        n_cur_slot   = r_cur_slot;
        n_cur_valid  = r_cur_valid;
        n_cur_id     = r_cur_id;
        n_out_valid  = 1'b0;
        n_action     = r_action;
        n_target     = r_target;
        n_parent     = r_parent;
        n_perm       = r_perm;
        n_addr       = r_addr;
        n_fresh      = r_fresh;
        n_cur_ref    = r_cur_ref;
        n_bad_idx    = r_bad_idx;
        n_prev_slot  = r_prev_slot;
        n_code       = r_code;
        n_res_id     = r_res_id;
        n_res_slot   = r_res_slot;
        n_res_state  = r_res_state;
        n_res_parent = r_res_parent;
        n_res_runs   = r_res_runs;
        w_main_we    = 1'b0;
        w_st_we      = 1'b0;
        w_waddr      = r_addr;
        w_main_wdata = w_main_rdata;
        w_st_wdata   = w_rd_state;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // Latch the command beat; memory read is under way
                    n_action  = t_action'(i_action);
                    n_target  = i_target_id;
                    n_parent  = i_parent_ident;
                    n_perm    = i_check_permission;
                    n_addr    = w_raddr;
                    n_fresh   = (HW'(w_raddr) >= r_fill);
                    n_cur_ref = (i_target_id == '0);
                    n_bad_idx = (w_idx32 >= 32'(NUM_SLOTS));
                    n_state   = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state      = S_IDLE;
                n_out_valid  = 1'b1;
                n_code       = RC_OK;
                n_res_id     = w_rd_id;
                n_res_slot   = w_slot32[SLOT_W-1:0];
                n_res_state  = w_rd_state;
                n_res_parent = w_rd_parent;
                n_res_runs   = w_rd_runs;

                if (r_action == ACT_ALLOC) begin
                    if (r_free_head >= HEAD_EMPTY) begin
                        n_code       = RC_NOFREE;
                        n_res_id     = '0;
                        n_res_slot   = '0;
                        n_res_state  = ES_FREE;
                        n_res_parent = '0;
                        n_res_runs   = '0;
                    end else begin
                        // Pop the free list and write the fresh entry
                        w_main_we    = 1'b1;
                        w_main_wdata = {w_rd_next, {RUNS_W{1'b0}}, r_parent, w_new_id};
                        w_st_we      = 1'b1;
                        w_st_wdata   = ES_RUNNABLE;
                        n_free_head  = w_rd_next;
                        if (r_fresh) begin
                            n_fill = r_fill + HW'(1);
                        end
                        n_res_id     = w_new_id;
                        n_res_state  = ES_RUNNABLE;
                        n_res_parent = r_parent;
                        n_res_runs   = '0;
                    end
                end else if (!w_resolved) begin
                    n_code       = RC_BAD;
                    n_res_id     = '0;
                    n_res_slot   = '0;
                    n_res_state  = ES_FREE;
                    n_res_parent = '0;
                    n_res_runs   = '0;
                end else if (r_action == ACT_DESTROY) begin
                    w_st_we = 1'b1;
                    if ((w_rd_state == ES_RUNNING) && !w_is_cur) begin
                        // Running elsewhere: mark dying, keep the slot
                        w_st_wdata  = ES_DYING;
                        n_res_state = ES_DYING;
                    end else begin
                        // Free: push onto the free list
                        w_st_wdata   = ES_FREE;
                        w_main_we    = 1'b1;
                        w_main_wdata = {r_free_head, w_rd_runs, w_rd_parent, w_rd_id};
                        n_free_head  = HW'(r_addr);
                        n_res_state  = ES_FREE;
                        if (w_is_cur) begin
                            n_cur_valid = 1'b0;
                        end
                    end
                end else if (r_action == ACT_RUN) begin
                    w_main_we    = 1'b1;
                    w_main_wdata = {w_rd_next, w_rd_runs + RUNS_W'(1), w_rd_parent, w_rd_id};
                    w_st_we      = 1'b1;
                    w_st_wdata   = ES_RUNNING;
                    n_res_state  = ES_RUNNING;
                    n_res_runs   = w_rd_runs + RUNS_W'(1);
                    // A valid current entry is always running; hand it back to
                    // runnable in the S_FIX state when switching away from it
                    if (r_cur_valid && (r_cur_slot != r_addr)) begin
                        n_prev_slot = r_cur_slot;
                        n_state     = S_FIX;
                    end
                    n_cur_slot  = r_addr;
                    n_cur_valid = 1'b1;
                    n_cur_id    = w_rd_id;
                end
            end

            S_FIX: begin
                w_waddr    = r_prev_slot;
                w_st_we    = 1'b1;
                w_st_wdata = ES_RUNNABLE;
                n_state    = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_fill      <= '0;
            r_cur_slot  <= '0;
            r_cur_valid <= 1'b0;
            r_cur_id    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_fill      <= n_fill;
            r_cur_slot  <= n_cur_slot;
            r_cur_valid <= n_cur_valid;
            r_cur_id    <= n_cur_id;
            r_out_valid <= n_out_valid;
        end
        r_action     <= n_action;
        r_target     <= n_target;
        r_parent     <= n_parent;
        r_perm       <= n_perm;
        r_addr       <= n_addr;
        r_fresh      <= n_fresh;
        r_cur_ref    <= n_cur_ref;
        r_bad_idx    <= n_bad_idx;
        r_prev_slot  <= n_prev_slot;
        r_code       <= n_code;
        r_res_id     <= n_res_id;
        r_res_slot   <= n_res_slot;
        r_res_state  <= n_res_state;
        r_res_parent <= n_res_parent;
        r_res_runs   <= n_res_runs;
    end

    assign o_result_valid = r_out_valid;
    assign o_result_code  = r_code;
    assign o_result_id    = r_res_id;
    assign o_slot_index   = r_res_slot;
    assign o_entry_state  = r_res_state;
    assign o_entry_parent = r_res_parent;
    assign o_entry_runs   = r_res_runs;

endmodule
`default_nettype wire

// File: verif/generational_handle_table_tb.sv
`timescale 1ns / 1ps
module generational_handle_table_tb;
    import ght_pkg::*;

    localparam int SLOTS       = ght_pkg::NUM_SLOTS_DEF;
    localparam int GSHIFT      = ght_pkg::GEN_SHIFT_DEF;
    localparam int CYCLE_LIMIT = 200000;
    // A run that switches entries is the longest command; allow a good margin past it.
    localparam int DRAIN_CYCLES = 16;
    localparam logic [31:0] IDX_MASK = (32'd1 << GSHIFT) - 32'd1;

    typedef struct packed {
        logic [1:0]         code;
        logic [ID_W-1:0]    id;
        logic [SLOT_W-1:0]  slot;
        logic [STATE_W-1:0] state;
        logic [ID_W-1:0]    parent;
        logic [RUNS_W-1:0]  runs;
    } t_handle_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_action;
    logic [ID_W-1:0]    i_target_id;
    logic [ID_W-1:0]    i_parent_ident;
    logic               i_check_permission;
    logic               o_result_valid;
    logic [1:0]         o_result_code;
    logic [ID_W-1:0]    o_result_id;
    logic [SLOT_W-1:0]  o_slot_index;
    logic [STATE_W-1:0] o_entry_state;
    logic [ID_W-1:0]    o_entry_parent;
    logic [RUNS_W-1:0]  o_entry_runs;

    generational_handle_table dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_action           (i_action),
        .i_target_id        (i_target_id),
        .i_parent_ident     (i_parent_ident),
        .i_check_permission (i_check_permission),
        .o_result_valid     (o_result_valid),
        .o_result_code      (o_result_code),
        .o_result_id        (o_result_id),
        .o_slot_index       (o_slot_index),
        .o_entry_state      (o_entry_state),
        .o_entry_parent     (o_entry_parent),
        .o_entry_runs       (o_entry_runs)
    );

    // Shadow copy of the handle table, advanced once per accepted command beat.
    int                 free_link [SLOTS];
    int                 free_head;
    logic [ID_W-1:0]    tbl_ids [SLOTS];
    logic [STATE_W-1:0] tbl_states [SLOTS];
    logic [ID_W-1:0]    tbl_parents [SLOTS];
    logic [RUNS_W-1:0]  tbl_runs [SLOTS];
    int                 cur_slot;
    bit                 cur_valid;

    t_handle_result     expected_results [$];
    t_handle_result     head_result;
    int                 n_errors;
    int                 n_accepted;
    int                 n_by_action [4];
    int                 n_by_code [4];
    int                 cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Bring the shadow table to its post-reset contents.
    task automatic clear_tables();
        for (int s = 0; s < SLOTS; s++) begin
            free_link[s]   = s + 1;
            tbl_ids[s]     = '0;
            tbl_states[s]  = ES_FREE;
            tbl_parents[s] = '0;
            tbl_runs[s]    = '0;
        end
        free_head = 0;
        cur_slot  = 0;
        cur_valid = 1'b0;
    endtask

    // Map an identifier to its slot, applying the staleness and parent rules.
    function automatic bit resolve_handle(input logic [ID_W-1:0] id, input logic perm,
                                          output int slot);
        int              idx;
        logic [ID_W-1:0] cur_id;
        slot = 0;
        // Identifier zero names the current entry and skips the parent rule.
        if (id == '0) begin
            slot = cur_slot;
            return cur_valid;
        end
        idx = int'(id[GSHIFT-1:0]);
        if (idx >= SLOTS)
            return 1'b0;
        if (tbl_states[idx] == ES_FREE || tbl_ids[idx] != id)
            return 1'b0;
        if (perm) begin
            // With nothing current the caller's own identifier counts as zero.
            cur_id = cur_valid ? tbl_ids[cur_slot] : '0;
            if (!(cur_valid && cur_slot == idx) && tbl_parents[idx] != cur_id)
                return 1'b0;
        end
        slot = idx;
        return 1'b1;
    endfunction

    // Apply one command to the shadow table and return the result it must give.
    function automatic t_handle_result apply_command(input logic [1:0] act,
                                                     input logic [ID_W-1:0] tgt,
                                                     input logic [ID_W-1:0] par,
                                                     input logic perm);
        t_handle_result r;
        int             slot;
        logic [31:0]    gen;
        bit             cur_hit;
        r = '0;
        if (act == ACT_ALLOC) begin
            if (free_head >= SLOTS) begin
                r.code = RC_NOFREE;
                return r;
            end
            slot = free_head;
            // Bump the generation; fall back to the first one on wrap or sign overflow.
            gen = ({1'b0, tbl_ids[slot]} + (32'd1 << GSHIFT)) & ~IDX_MASK;
            if (gen == '0 || gen[31])
                gen = 32'd1 << GSHIFT;
            tbl_ids[slot]     = ID_W'(gen | 32'(slot));
            tbl_parents[slot] = par;
            tbl_states[slot]  = ES_RUNNABLE;
            tbl_runs[slot]    = '0;
            free_head         = free_link[slot];
        end else begin
            if (!resolve_handle(tgt, perm, slot)) begin
                r.code = RC_BAD;
                return r;
            end
            cur_hit = cur_valid && cur_slot == slot;
            if (act == ACT_DESTROY) begin
                // A running entry owned by someone else only goes to dying.
                if (tbl_states[slot] == ES_RUNNING && !cur_hit) begin
                    tbl_states[slot] = ES_DYING;
                end else begin
                    tbl_states[slot] = ES_FREE;
                    free_link[slot]  = free_head;
                    free_head        = slot;
                    if (cur_hit)
                        cur_valid = 1'b0;
                end
            end else if (act == ACT_RUN) begin
                if (cur_valid && tbl_states[cur_slot] == ES_RUNNING)
                    tbl_states[cur_slot] = ES_RUNNABLE;
                cur_slot         = slot;
                cur_valid        = 1'b1;
                tbl_states[slot] = ES_RUNNING;
                tbl_runs[slot]   = tbl_runs[slot] + 1'b1;
            end
        end
        r.code   = RC_OK;
        r.id     = tbl_ids[slot];
        r.slot   = SLOT_W'(slot);
        r.state  = tbl_states[slot];
        r.parent = tbl_parents[slot];
        r.runs   = tbl_runs[slot];
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endfunction

    // Result checker and command monitor. Check first: a result shown at the same
    // edge as a new command beat always belongs to an older command.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_result_valid === 1'b1) begin
                if (expected_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: stray result beat, expected none, actual code %h id %h",
                             $time, o_result_code, o_result_id);
                end else begin
                    head_result = expected_results.pop_front();
                    check_field("result_code", 32'(head_result.code), 32'(o_result_code));
                    check_field("result_id", 32'(head_result.id), 32'(o_result_id));
                    check_field("slot_index", 32'(head_result.slot), 32'(o_slot_index));
                    check_field("entry_state", 32'(head_result.state), 32'(o_entry_state));
                    check_field("entry_parent", 32'(head_result.parent),
                                32'(o_entry_parent));
                    check_field("entry_runs", head_result.runs, o_entry_runs);
                    n_by_code[head_result.code]++;
                end
            end else if (o_result_valid !== 1'b0) begin
                n_errors++;
                $display("%0t: o_result_valid unknown, expected 0 or 1, actual %b",
                         $time, o_result_valid);
            end
            if (start === 1'b1 && busy === 1'b0) begin
                expected_results.push_back(apply_command(i_action, i_target_id,
                                                         i_parent_ident,
                                                         i_check_permission));
                n_accepted++;
                n_by_action[i_action]++;
            end
        end
    end

    // Watchdog: end the run if the block stops answering.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Send one command beat. Called at a falling edge; returns at the falling edge
    // after the beat is taken, with start still high so back-to-back beats need
    // no extra toggle.
    task automatic send_cmd(input int idle_pct, input logic [1:0] act,
                            input logic [ID_W-1:0] tgt, input logic [ID_W-1:0] par,
                            input logic perm);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start              <= 1'b1;
        i_action           <= act;
        i_target_id        <= tgt;
        i_parent_ident     <= par;
        i_check_permission <= perm;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Pick a slot in use (live) or a freed slot that still holds an old identifier.
    function automatic int pick_slot(input bit live);
        int hits [$];
        for (int s = 0; s < SLOTS; s++) begin
            if (live ? (tbl_states[s] != ES_FREE)
                     : (tbl_states[s] == ES_FREE && tbl_ids[s] != '0))
                hits.push_back(s);
        end
        if (hits.size() == 0)
            return -1;
        return hits[$urandom_range(hits.size() - 1)];
    endfunction

    // Mostly live identifiers, with the current shorthand, stale and wild ones mixed in.
    function automatic logic [ID_W-1:0] choose_target();
        int sel;
        int s;
        sel = $urandom_range(99);
        if (sel < 58) begin
            s = pick_slot(1'b1);
            if (s >= 0)
                return tbl_ids[s];
        end else if (sel < 68) begin
            return '0;
        end else if (sel < 80) begin
            s = pick_slot(1'b0);
            if (s >= 0)
                return tbl_ids[s];
        end else if (sel < 88) begin
            // Flip one generation bit of a live identifier to make it stale.
            s = pick_slot(1'b1);
            if (s >= 0)
                return tbl_ids[s] ^ (ID_W'(1) << $urandom_range(ID_W - 1, GSHIFT));
        end
        return ID_W'($urandom());
    endfunction

    // Favour the current entry as parent so the permission rule passes often.
    function automatic logic [ID_W-1:0] choose_parent();
        int sel;
        int s;
        sel = $urandom_range(99);
        if (sel < 45)
            return cur_valid ? tbl_ids[cur_slot] : '0;
        if (sel < 65)
            return '0;
        if (sel < 80) begin
            s = pick_slot(1'b1);
            if (s >= 0)
                return tbl_ids[s];
        end
        return ID_W'($urandom());
    endfunction

    // Nothing allocated yet: every lookup, run and destroy must be refused.
    task automatic test_reset_state();
        send_cmd(0, ACT_LOOKUP, '0, '0, 1'b0);
        send_cmd(0, ACT_RUN, '0, '0, 1'b1);
        send_cmd(0, ACT_DESTROY, '0, '0, 1'b0);
        send_cmd(0, ACT_LOOKUP, ID_W'(32'd1 << GSHIFT), '0, 1'b0);
    endtask

    task automatic test_alloc_lookup();
        send_cmd(0, ACT_ALLOC, '0, '0, 1'b0);
        send_cmd(0, ACT_ALLOC, '1, '1, 1'b1);
        send_cmd(0, ACT_LOOKUP, tbl_ids[0], '0, 1'b0);
        // Index bits beyond the table: rejected whatever the generation.
        send_cmd(0, ACT_LOOKUP, '1, '0, 1'b0);
        send_cmd(0, ACT_LOOKUP, ID_W'(IDX_MASK), '0, 1'b0);
        // No current entry: only entries with a zero parent pass the parent rule.
        send_cmd(0, ACT_LOOKUP, tbl_ids[1], '0, 1'b1);
        send_cmd(0, ACT_LOOKUP, tbl_ids[0], '0, 1'b1);
    endtask

    task automatic test_run_switch();
        send_cmd(0, ACT_RUN, tbl_ids[0], '0, 1'b0);
        send_cmd(0, ACT_ALLOC, '0, tbl_ids[0], 1'b0);
        send_cmd(0, ACT_LOOKUP, tbl_ids[2], '0, 1'b1);
        send_cmd(0, ACT_LOOKUP, tbl_ids[1], '0, 1'b1);
        send_cmd(0, ACT_LOOKUP, '0, '0, 1'b1);
        send_cmd(0, ACT_RUN, tbl_ids[2], '0, 1'b1);
        send_cmd(0, ACT_RUN, '0, '0, 1'b0);
    endtask

    task automatic test_destroy_reuse();
        logic [ID_W-1:0] old_id;
        old_id = tbl_ids[1];
        send_cmd(0, ACT_DESTROY, old_id, '0, 1'b0);
        send_cmd(0, ACT_LOOKUP, old_id, '0, 1'b0);
        // Slot 1 sits at the head of the free list and comes back one generation on.
        send_cmd(0, ACT_ALLOC, '0, '0, 1'b0);
        send_cmd(0, ACT_RUN, old_id, '0, 1'b0);
        // Destroy the current entry: nothing is current afterwards.
        send_cmd(0, ACT_DESTROY, '0, '0, 1'b1);
        send_cmd(0, ACT_LOOKUP, '0, '0, 1'b0);
        send_cmd(0, ACT_DESTROY, tbl_ids[0], '0, 1'b0);
    endtask

    // Fill every slot and hit the empty free list; leave the table full so the
    // random mix starts from refused allocations and reuses freed slots.
    task automatic test_table_full();
        while (free_head < SLOTS)
            send_cmd(5, ACT_ALLOC, ID_W'($urandom()), choose_parent(),
                     1'($urandom_range(1)));
        for (int n = 0; n < 3; n++)
            send_cmd(5, ACT_ALLOC, ID_W'($urandom()), ID_W'($urandom()),
                     1'($urandom_range(1)));
        send_cmd(5, ACT_RUN, tbl_ids[SLOTS - 1], '0, 1'b0);
        send_cmd(5, ACT_LOOKUP, tbl_ids[SLOTS / 2], '0, 1'b1);
    endtask

    // Random command mix. Most beats carry plausible identifiers so that the
    // parent and run rules get exercised; a tenth are pure noise.
    task automatic test_random_ops(input int idle_pct, input int n_items);
        int         sel;
        logic [1:0] act;
        for (int n = 0; n < n_items; n++) begin
            sel = $urandom_range(99);
            if (sel < 30)
                act = ACT_ALLOC;
            else if (sel < 55)
                act = ACT_LOOKUP;
            else if (sel < 75)
                act = ACT_DESTROY;
            else
                act = ACT_RUN;
            if ($urandom_range(9) == 0)
                send_cmd(idle_pct, 2'($urandom()), ID_W'($urandom()), ID_W'($urandom()),
                         1'($urandom_range(1)));
            else
                send_cmd(idle_pct, act, choose_target(), choose_parent(),
                         1'($urandom_range(1)));
        end
    endtask

    initial begin
        n_errors   = 0;
        n_accepted = 0;
        for (int k = 0; k < 4; k++) begin
            n_by_action[k] = 0;
            n_by_code[k]   = 0;
        end
        clear_tables();
        // Hold every input at a known value through reset.
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_action           = ACT_ALLOC;
        i_target_id        = '0;
        i_parent_ident     = '0;
        i_check_permission = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_alloc_lookup();
        test_run_switch();
        test_destroy_reuse();
        test_table_full();
        test_random_ops(32, 40);
        test_random_ops(79, 40);
        test_random_ops(0, 40);

        start <= 1'b0;
        // Drain outstanding results, then watch a while longer for stray beats.
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands: %0d allocate, %0d lookup, %0d destroy, %0d run",
                 n_accepted, n_by_action[ACT_ALLOC], n_by_action[ACT_LOOKUP],
                 n_by_action[ACT_DESTROY], n_by_action[ACT_RUN]);
        $display("Answers: %0d ok, %0d table full, %0d bad or stale identifier",
                 n_by_code[RC_OK], n_by_code[RC_NOFREE], n_by_code[RC_BAD]);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
